@@ hw/rtl/nmp_pkg.sv @@
package nmp_pkg;

    localparam int VEC_W   = 16;  // Q1.14 component
    localparam int BYTE_W  = 8;
    localparam int WGT_W   = 10;  // 2*t-255, signed
    localparam int PROD_W  = 32;  // 16x16 product
    localparam int CRS_W   = 33;  // cross component
    localparam int SUM_W   = 27;  // n*db + t*dr
    localparam int CG_W    = 43;  // cross * dg
    localparam int V_W     = 44;  // summed component
    localparam int MAG_W   = 41;  // |v| < 2^40
    localparam int SH_W    = 6;
    localparam int SQ_W    = 32;
    localparam int LEN_W   = 34;
    localparam int Q_W     = 15;  // 0..16384
    localparam int RL_W    = 50;
    localparam int R2L_W   = 68;
    localparam int QBITS   = 15;  // bit-per-stage square-root steps

    // side band carried with every sample
    typedef struct packed {
        logic [2:0]              neg;
        logic                    zero;
        logic signed [VEC_W-1:0] nx;
        logic signed [VEC_W-1:0] ny;
        logic signed [VEC_W-1:0] nz;
    } t_side;

endpackage

@@ hw/rtl/normal_map_perturb.sv @@
// Tangent-space normal perturbation, fully pipelined.
// Throughput: one sample per clock; busy is never raised.
// Pipeline depth: 26 register stages (ten arithmetic, fifteen root, one output) from
//   start to o_valid.
// Reset (synchronous, active low) clears only the valid bits of the pipe.
// The receiver cannot stall; each result strobes for exactly one cycle.
module normal_map_perturb (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_tangent_x,
    input  logic signed [15:0] i_tangent_y,
    input  logic signed [15:0] i_tangent_z,
    input  logic [7:0]         i_map_red,
    input  logic [7:0]         i_map_green,
    input  logic [7:0]         i_map_blue,
    output logic               o_valid,
    output logic signed [15:0] o_bent_x,
    output logic signed [15:0] o_bent_y,
    output logic signed [15:0] o_bent_z,
    output logic               o_degenerate
);
    import nmp_pkg::*;

    // Pipe never blocks, so a start is always taken.
    assign busy = 1'b0;

    // ---------------- stage 1: capture, decode byte weights ----------------
    logic                      r_v1;
    logic signed [VEC_W-1:0]   r_n1 [3];
    logic signed [VEC_W-1:0]   r_t1 [3];
    logic signed [WGT_W-1:0]   r_dr1, r_dg1, r_db1;

    function automatic logic signed [WGT_W-1:0] dec(input logic [BYTE_W-1:0] b);
        dec = $signed({1'b0, b, 1'b0}) - WGT_W'(255);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start;
        r_n1[0] <= i_normal_x;  r_n1[1] <= i_normal_y;  r_n1[2] <= i_normal_z;
        r_t1[0] <= i_tangent_x; r_t1[1] <= i_tangent_y; r_t1[2] <= i_tangent_z;
        r_dr1 <= dec(i_map_red);
        r_dg1 <= dec(i_map_green);
        r_db1 <= dec(i_map_blue);
    end

    // ---------------- stage 2: all single products ----------------
    logic                      r_v2;
    t_side                     r_sd2;
    logic signed [PROD_W-1:0]  r_pa2 [3];  // first term of each cross component
    logic signed [PROD_W-1:0]  r_pb2 [3];  // subtracted term
    logic signed [SUM_W-2:0]   r_nb2 [3];
    logic signed [SUM_W-2:0]   r_tr2 [3];
    logic signed [WGT_W-1:0]   r_dg2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_sd2.neg  <= '0;
        r_sd2.zero <= 1'b0;
        r_sd2.nx   <= r_n1[0];
        r_sd2.ny   <= r_n1[1];
        r_sd2.nz   <= r_n1[2];
        r_pa2[0] <= r_t1[1] * r_n1[2];  r_pb2[0] <= r_t1[2] * r_n1[1];
        r_pa2[1] <= r_t1[2] * r_n1[0];  r_pb2[1] <= r_t1[0] * r_n1[2];
        r_pa2[2] <= r_t1[0] * r_n1[1];  r_pb2[2] <= r_t1[1] * r_n1[0];
        for (int i = 0; i < 3; i++) begin
            r_nb2[i] <= r_n1[i] * r_db1;
            r_tr2[i] <= r_t1[i] * r_dr1;
        end
        r_dg2 <= r_dg1;
    end

    // ---------------- stage 3: cross differences, weighted sum ----------------
    logic                      r_v3;
    t_side                     r_sd3;
    logic signed [CRS_W-1:0]   r_c3 [3];
    logic signed [SUM_W-1:0]   r_s3 [3];
    logic signed [WGT_W-1:0]   r_dg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_sd3 <= r_sd2;
        for (int i = 0; i < 3; i++) begin
            r_c3[i] <= CRS_W'(r_pa2[i]) - CRS_W'(r_pb2[i]);
            r_s3[i] <= SUM_W'(r_nb2[i]) + SUM_W'(r_tr2[i]);
        end
        r_dg3 <= r_dg2;
    end

    // ---------------- stage 4: weight the cross product ----------------
    logic                      r_v4;
    t_side                     r_sd4;
    logic signed [CG_W-1:0]    r_cg4 [3];
    logic signed [SUM_W-1:0]   r_s4 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_sd4 <= r_sd3;
        for (int i = 0; i < 3; i++) begin
            r_cg4[i] <= r_c3[i] * r_dg3;
            r_s4[i]  <= r_s3[i];
        end
    end

    // ---------------- stage 5: V, scaled by 255*2^28 ----------------
    logic                      r_v5;
    t_side                     r_sd5;
    logic signed [V_W-1:0]     r_vv5 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
        r_sd5 <= r_sd4;
        for (int i = 0; i < 3; i++)
            r_vv5[i] <= (V_W'(r_s4[i]) <<< 14) + V_W'(r_cg4[i]);
    end

    // ---------------- stage 6: magnitudes, signs, zero test ----------------
    logic                      r_v6;
    t_side                     r_sd6;
    logic [MAG_W-1:0]          r_a6 [3];
    logic [MAG_W-1:0]          r_or6;
    logic [MAG_W-1:0]          n_a6 [3];

    always_comb begin
        for (int i = 0; i < 3; i++)
            n_a6[i] = r_vv5[i][V_W-1] ? MAG_W'(-r_vv5[i]) : MAG_W'(r_vv5[i]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else          r_v6 <= r_v5;
        r_sd6.nx   <= r_sd5.nx;
        r_sd6.ny   <= r_sd5.ny;
        r_sd6.nz   <= r_sd5.nz;
        r_sd6.neg  <= {r_vv5[2][V_W-1], r_vv5[1][V_W-1], r_vv5[0][V_W-1]};
        r_sd6.zero <= (r_vv5[0] == '0) && (r_vv5[1] == '0) && (r_vv5[2] == '0);
        r_a6  <= n_a6;
        // the top set bit of the OR is the top set bit of the largest magnitude
        r_or6 <= n_a6[0] | n_a6[1] | n_a6[2];
    end

    // ---------------- stage 7: shift count from leading one ----------------
    logic                      r_v7;
    t_side                     r_sd7;
    logic [MAG_W-1:0]          r_a7 [3];
    logic [SH_W-1:0]           r_sh7;
    logic [SH_W-1:0]           n_msb;

    always_comb begin
        n_msb = '0;
        for (int k = 0; k < MAG_W; k++)
            if (r_or6[k]) n_msb = SH_W'(k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else          r_v7 <= r_v6;
        r_sd7 <= r_sd6;
        r_a7  <= r_a6;
        r_sh7 <= (n_msb > SH_W'(15)) ? n_msb - SH_W'(15) : '0;
    end

    // ---------------- stage 8: bring the largest magnitude under 2^16 ----------------
    logic                      r_v8;
    t_side                     r_sd8;
    logic [VEC_W-1:0]          r_w8 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v8 <= 1'b0;
        else          r_v8 <= r_v7;
        r_sd8 <= r_sd7;
        for (int i = 0; i < 3; i++)
            r_w8[i] <= VEC_W'(r_a7[i] >> r_sh7);
    end

    // ---------------- stage 9: squares ----------------
    logic                      r_v9;
    t_side                     r_sd9;
    logic [SQ_W-1:0]           r_sq9 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v9 <= 1'b0;
        else          r_v9 <= r_v8;
        r_sd9 <= r_sd8;
        for (int i = 0; i < 3; i++)
            r_sq9[i] <= r_w8[i] * r_w8[i];
    end

    // ---------------- root pipe state ----------------
    // For each component find the largest q with (2q-1)^2*L <= 2^30*w^2.
    // rl = q*L and r2l = q^2*L are kept so each trial needs only shifts and adds.
    logic                      r_vb   [QBITS+1];
    t_side                     r_sdb  [QBITS+1];
    logic [LEN_W-1:0]          r_lenb [QBITS+1];
    logic [SQ_W-1:0]           r_sqb  [QBITS+1][3];
    logic [Q_W-1:0]            r_qb   [QBITS+1][3];
    logic [RL_W-1:0]           r_rlb  [QBITS+1][3];
    logic [R2L_W-1:0]          r_r2lb [QBITS+1][3];

    // ---------------- stage 10: squared length, seed the root stages ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb[0] <= 1'b0;
        else          r_vb[0] <= r_v9;
        r_sdb[0]  <= r_sd9;
        r_lenb[0] <= LEN_W'(r_sq9[0]) + LEN_W'(r_sq9[1]) + LEN_W'(r_sq9[2]);
        for (int i = 0; i < 3; i++) begin
            r_sqb[0][i]  <= r_sq9[i];
            r_qb[0][i]   <= '0;
            r_rlb[0][i]  <= '0;
            r_r2lb[0][i] <= '0;
        end
    end

    // ---------------- root stages: one output bit per stage ----------------
    for (genvar j = 0; j < QBITS; j++) begin : g_root
        localparam int B = QBITS - 1 - j;

        logic [RL_W-1:0]   n_rl  [3];
        logic [R2L_W-1:0]  n_r2l [3];
        logic [R2L_W-1:0]  n_test[3];
        logic [2:0]        n_take;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_rl[i]   = r_rlb[j][i] + (RL_W'(r_lenb[j]) << B);
                n_r2l[i]  = r_r2lb[j][i] + (R2L_W'(r_rlb[j][i]) << (B + 1))
                          + (R2L_W'(r_lenb[j]) << (2 * B));
                // (2c-1)^2*L = 4c^2L - 4cL + L
                n_test[i] = (n_r2l[i] << 2) - (R2L_W'(n_rl[i]) << 2)
                          + R2L_W'(r_lenb[j]);
                // a set top bit means q already sits at one; drop further bits
                n_take[i] = !r_qb[j][i][Q_W-1]
                          && (n_test[i] <= (R2L_W'(r_sqb[j][i]) << 30));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vb[j+1] <= 1'b0;
            else          r_vb[j+1] <= r_vb[j];
            r_sdb[j+1]  <= r_sdb[j];
            r_lenb[j+1] <= r_lenb[j];
            for (int i = 0; i < 3; i++) begin
                r_sqb[j+1][i] <= r_sqb[j][i];
                if (n_take[i]) begin
                    r_qb[j+1][i]   <= r_qb[j][i] | (Q_W'(1) << B);
                    r_rlb[j+1][i]  <= n_rl[i];
                    r_r2lb[j+1][i] <= n_r2l[i];
                end else begin
                    r_qb[j+1][i]   <= r_qb[j][i];
                    r_rlb[j+1][i]  <= r_rlb[j][i];
                    r_r2lb[j+1][i] <= r_r2lb[j][i];
                end
            end
        end
    end

    // ---------------- output register: signs, or pass the normal through ----------------
    logic                      r_vo;
    logic signed [VEC_W-1:0]   r_bo [3];
    logic                      r_dgo;
    logic signed [VEC_W-1:0]   n_bo [3];
    t_side                     n_sd;

    always_comb begin
        n_sd = r_sdb[QBITS];
        for (int i = 0; i < 3; i++)
            n_bo[i] = n_sd.neg[i] ? -VEC_W'(r_qb[QBITS][i]) : VEC_W'(r_qb[QBITS][i]);
        if (n_sd.zero) begin
            n_bo[0] = n_sd.nx;
            n_bo[1] = n_sd.ny;
            n_bo[2] = n_sd.nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vo <= 1'b0;
        else          r_vo <= r_vb[QBITS];
        r_bo  <= n_bo;
        r_dgo <= n_sd.zero;
    end

    assign o_valid      = r_vo;
    assign o_bent_x     = r_bo[0];
    assign o_bent_y     = r_bo[1];
    assign o_bent_z     = r_bo[2];
    assign o_degenerate = r_dgo;

endmodule

@@ verif/normal_map_perturb_tb.sv @@
`timescale 1ns / 100ps

module normal_map_perturb_tb;

    localparam int LATENCY   = 26;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 900;
    localparam int ONE_Q14   = 16384;

    typedef struct packed {
        logic signed [15:0] nx, ny, nz;
        logic signed [15:0] tx, ty, tz;
        logic [7:0]         red, green, blue;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] bx, by, bz;
        logic               degen;
    } t_bent;

    // One row of the directed table: the sample plus an optional typed-in answer.
    typedef struct {
        t_sample s;
        bit      known;
        t_bent   ans;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [15:0] i_tangent_x, i_tangent_y, i_tangent_z;
    logic [7:0]         i_map_red, i_map_green, i_map_blue;
    logic               o_valid;
    logic signed [15:0] o_bent_x, o_bent_y, o_bent_z;
    logic               o_degenerate;

    t_bent  pending_normals[$];
    int     n_errors;
    int     n_sent;
    int     n_checked;
    int     n_degen;
    int     idle_cycles;

    normal_map_perturb DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_tangent_x  (i_tangent_x),
        .i_tangent_y  (i_tangent_y),
        .i_tangent_z  (i_tangent_z),
        .i_map_red    (i_map_red),
        .i_map_green  (i_map_green),
        .i_map_blue   (i_map_blue),
        .o_valid      (o_valid),
        .o_bent_x     (o_bent_x),
        .o_bent_y     (o_bent_y),
        .o_bent_z     (o_bent_z),
        .o_degenerate (o_degenerate)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Largest q in [0,16384] with (2q-1)^2 * len2 <= 2^30 * a^2, built bit by bit.
    function automatic longint unsigned unit_component(longint unsigned a,
                                                       longint unsigned len2);
        longint unsigned rhs;
        longint unsigned q;
        longint unsigned cand;
        longint unsigned k;
        rhs = (a * a) << 30;
        q   = 0;
        for (int b = 14; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            if (cand <= ONE_Q14) begin
                k = 2 * cand - 1;
                if (k * k * len2 <= rhs)
                    q = cand;
            end
        end
        return q;
    endfunction

    // Perturb the normal by the texel: V = N*b + T*r + (T x N)*g, then normalise.
    function automatic t_bent bend_normal(t_sample s);
        longint n[3], t[3], c[3], v[3];
        longint dr, dg, db;
        longint unsigned mag[3];
        longint unsigned mx, len2, q;
        logic [15:0] comp[3];
        t_bent r;
        n[0] = s.nx; n[1] = s.ny; n[2] = s.nz;
        t[0] = s.tx; t[1] = s.ty; t[2] = s.tz;
        dr = 2 * longint'(s.red)   - 255;
        dg = 2 * longint'(s.green) - 255;
        db = 2 * longint'(s.blue)  - 255;
        c[0] = t[1] * n[2] - t[2] * n[1];
        c[1] = t[2] * n[0] - t[0] * n[2];
        c[2] = t[0] * n[1] - t[1] * n[0];
        for (int i = 0; i < 3; i++)
            v[i] = n[i] * ONE_Q14 * db + t[i] * ONE_Q14 * dr + c[i] * dg;
        if (v[0] == 0 && v[1] == 0 && v[2] == 0) begin
            r.bx = s.nx; r.by = s.ny; r.bz = s.nz; r.degen = 1'b1;
            return r;
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        // shrink all magnitudes together until the largest fits in 16 bits
        while (mx >= 64'd65536) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        for (int i = 0; i < 3; i++) begin
            q = unit_component(mag[i], len2);
            if (v[i] < 0)
                q = -q;
            comp[i] = q[15:0];
        end
        r.bx = comp[0]; r.by = comp[1]; r.bz = comp[2]; r.degen = 1'b0;
        return r;
    endfunction

    function automatic t_row mk_row(int nx, int ny, int nz, int tx, int ty, int tz,
                                    int red, int green, int blue,
                                    bit known, int bx, int by, int bz, bit degen);
        t_row r;
        r.s.nx = 16'(nx); r.s.ny = 16'(ny); r.s.nz = 16'(nz);
        r.s.tx = 16'(tx); r.s.ty = 16'(ty); r.s.tz = 16'(tz);
        r.s.red = 8'(red); r.s.green = 8'(green); r.s.blue = 8'(blue);
        r.known = known;
        r.ans.bx = 16'(bx); r.ans.by = 16'(by); r.ans.bz = 16'(bz); r.ans.degen = degen;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_comp();
        // mostly in range, now and then any 16-bit pattern
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        int pick;
        s.nx = rand_comp(); s.ny = rand_comp(); s.nz = rand_comp();
        s.tx = rand_comp(); s.ty = rand_comp(); s.tz = rand_comp();
        s.red = 8'($urandom); s.green = 8'($urandom); s.blue = 8'($urandom);
        pick = $urandom_range(0, 9);
        // steer some samples towards degenerate sums
        if (pick == 0) begin
            s.nx = '0; s.ny = '0; s.nz = '0; s.tx = '0; s.ty = '0; s.tz = '0;
        end else if (pick == 1) begin
            // T = N, weights cancel: blue + red = 255
            s.tx = s.nx; s.ty = s.ny; s.tz = s.nz;
            s.blue = 8'd255 - s.red;
        end else if (pick == 2) begin
            // T = -N, equal weights cancel
            s.tx = -s.nx; s.ty = -s.ny; s.tz = -s.nz;
            s.blue = s.red;
        end
        return s;
    endfunction

    // Drive one transfer at the falling edge and hold until the block takes it.
    task automatic send_sample(t_sample s);
        start       <= 1'b1;
        i_normal_x  <= s.nx;  i_normal_y  <= s.ny;  i_normal_z  <= s.nz;
        i_tangent_x <= s.tx;  i_tangent_y <= s.ty;  i_tangent_z <= s.tz;
        i_map_red   <= s.red; i_map_green <= s.green; i_map_blue <= s.blue;
        do
            @(posedge i_clk);
        while (busy);
        n_sent++;
        @(negedge i_clk);
    endtask

    // A zero-length gap keeps start high into the next transfer.
    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Check every strobed result against the oldest expectation.
    always @(posedge i_clk) begin
        t_bent want;
        if (i_rst_n && o_valid) begin
            if (pending_normals.size() == 0) begin
                $error("unexpected result x=%0d y=%0d z=%0d", o_bent_x, o_bent_y, o_bent_z);
                n_errors++;
            end else begin
                want = pending_normals.pop_front();
                n_checked++;
                if (want.degen)
                    n_degen++;
                if (o_bent_x !== want.bx) begin
                    $error("bent_x expected %0d got %0d", want.bx, o_bent_x);
                    n_errors++;
                end
                if (o_bent_y !== want.by) begin
                    $error("bent_y expected %0d got %0d", want.by, o_bent_y);
                    n_errors++;
                end
                if (o_bent_z !== want.bz) begin
                    $error("bent_z expected %0d got %0d", want.bz, o_bent_z);
                    n_errors++;
                end
                if (o_degenerate !== want.degen) begin
                    $error("degenerate expected %0d got %0d", want.degen, o_degenerate);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        t_row    rows[$];
        t_sample s;
        t_bent   e;
        int      burst;
        n_sent      = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_normal_x  = '0; i_normal_y  = '0; i_normal_z  = '0;
        i_tangent_x = '0; i_tangent_y = '0; i_tangent_z = '0;
        i_map_red   = '0; i_map_green = '0; i_map_blue  = '0;

        // Directed table. Known answers: all-zero vectors pass the normal through,
        // a zero tangent with blue 255 yields N itself, and with blue 0 yields -N.
        rows = {rows, mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1)};
        rows = {rows, mk_row(0, 0, 0, 0, 0, 0, 255, 255, 255, 1, 0, 0, 0, 1)};
        rows = {rows, mk_row(0, 0, 16384, 16384, 0, 0, 127, 127, 255, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(0, 0, 16384, 0, 0, 0, 0, 0, 255, 1, 0, 0, 16384, 0)};
        rows = {rows, mk_row(0, 0, 16384, 0, 0, 0, 0, 0, 0, 1, 0, 0, -16384, 0)};
        rows = {rows, mk_row(16384, 0, 0, 0, 0, 0, 9, 200, 255, 1, 16384, 0, 0, 0)};
        rows = {rows, mk_row(0, -16384, 0, 0, 0, 0, 255, 0, 255, 1, 0, -16384, 0, 0)};
        // tangent only: weight of T dominates
        rows = {rows, mk_row(0, 0, 0, 16384, 0, 0, 255, 77, 3, 1, 16384, 0, 0, 0)};
        rows = {rows, mk_row(0, 0, 0, 0, -16384, 0, 0, 77, 3, 1, 0, 16384, 0, 0)};
        // T = N or T = -N with cancelling weights gives a zero sum: pass-through
        rows = {rows, mk_row(1000, -2000, 3000, 1000, -2000, 3000, 100, 9, 155,
                              1, 1000, -2000, 3000, 1)};
        rows = {rows, mk_row(-16384, 16384, -16384, 16384, -16384, 16384, 40, 250, 40,
                              1, -16384, 16384, -16384, 1)};
        // extremes of the word and of the bytes
        rows = {rows, mk_row(-32768, -32768, -32768, 32767, 32767, 32767, 255, 255, 255,
                              0, 0, 0, 0, 0)};
        rows = {rows, mk_row(32767, -32768, 1, -1, 32767, -32768, 0, 255, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(-1, -1, -1, -1, -1, -1, 128, 127, 128, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(16384, 16384, 16384, -16384, 16384, 0, 255, 255, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(0, 0, 16384, 16384, 0, 0, 200, 60, 230, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(0, 16384, 0, 0, 0, 16384, 0, 255, 128, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(11585, 0, 11585, 0, 16384, 0, 170, 85, 85, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(1, 0, 0, 0, 1, 0, 128, 128, 128, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(21845, -10922, 5461, -5461, 10922, -21845, 85, 170, 255,
                              0, 0, 0, 0, 0)};

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: back to back, then a short gap before the random part.
        foreach (rows[i]) begin
            e = rows[i].known ? rows[i].ans : bend_normal(rows[i].s);
            if (rows[i].known && e != bend_normal(rows[i].s))
                $display("tb: note, table row %0d differs from predictor", i);
            pending_normals = {pending_normals, e};
            send_sample(rows[i].s);
        end
        idle_gap(3);

        // Random part: bursts with random gaps, some long bursts with no gap.
        while (n_sent < rows.size() + N_RANDOM) begin
            burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
            for (int k = 0; k < burst; k++) begin
                s = rand_sample();
                pending_normals = {pending_normals, bend_normal(s)};
                send_sample(s);
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5));
        end
        start <= 1'b0;

        // Drain the pipe, then allow some slack for stray results.
        while (pending_normals.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);

        $display("tb: %0d samples sent, %0d results checked, %0d degenerate sums",
                 n_sent, n_checked, n_degen);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
